@@ design/assert_macros.svh @@
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pps_pkg.sv @@
`default_nettype none

package pps_pkg;

    // Capacity of the sorting chain and width of one stored value.
    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 16;
    // A pair sum needs one more bit; the target register has the same width.
    localparam int SUM_BITS   = VALUE_BITS + 1;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    // Command word broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop_left;
        logic pop_right;
        logic clear;
    } pps_ctrl_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        value_t value;
        logic   occ;
        logic   gt;
        logic   tail;
    } pps_link_t;

endpackage

`default_nettype wire

@@ design/sorted_two_pointer_pair_sum.sv @@
// Channel   Signals                                         Handshake
// input     value, last_item                                start & !busy
// config    pair_target                                     cfg_valid & cfg_ready
// result    low_value, high_value, found, dropped,          result_valid, one cycle
//           last_result
//
// Loading takes a word whenever start is high and busy is low; each word is inserted in
// sorted place by the cell chain at the edge that accepts it, or dropped if the chain is full.
// After the word marked last, busy stays high through the pointer steps of the scan
// and falls as the closing record appears.
// Each record shows for one cycle on result_valid; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) empties the chain and sets pair_target to 0.
`default_nettype none

module sorted_two_pointer_pair_sum (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire pps_pkg::value_t   value,
    input  wire                    last_item,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire pps_pkg::sum_t     pair_target,
    output logic                   result_valid,
    output pps_pkg::value_t        low_value,
    output pps_pkg::value_t        high_value,
    output logic                   found,
    output logic                   dropped,
    output logic                   last_result
);
    import pps_pkg::*;

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t    state_reg;
    logic      overflow_reg;
    sum_t      target_reg;
    logic      pend_valid_reg;
    value_t    pend_lo_reg;
    value_t    pend_hi_reg;
    logic      result_valid_reg;
    value_t    low_value_reg;
    value_t    high_value_reg;
    logic      found_reg;
    logic      dropped_reg;
    logic      last_result_reg;

    pps_ctrl_t ctrl;
    pps_link_t link [MAX_ITEMS];
    value_t    head_value;
    value_t    tail_value;
    sum_t      pair_sum;
    logic      accept;
    logic      chain_full;
    logic      two_left;

    localparam pps_link_t LOW_END  = '{value: '0, occ: 1'b1, gt: 1'b0, tail: 1'b0};
    localparam pps_link_t HIGH_END = '{value: '0, occ: 1'b0, gt: 1'b0, tail: 1'b0};

    // The sorting chain.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        pps_link_t lower;
        pps_link_t upper;
        if (i == 0)
        begin : g_lo
            assign lower = LOW_END;
        end
        else
        begin : g_lo
            assign lower = link[i-1];
        end
        if (i == MAX_ITEMS - 1)
        begin : g_hi
            assign upper = HIGH_END;
        end
        else
        begin : g_hi
            assign upper = link[i+1];
        end
        pps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_value (value),
            .lower     (lower),
            .upper     (upper),
            .link      (link[i])
        );
    end

    // The right pointer is the one cell that flags itself as the tail.
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            if (link[i].tail)
            begin
                tail_value = tail_value | link[i].value;
            end
        end
    end

    assign head_value = link[0].value;
    assign pair_sum   = SUM_BITS'(head_value) + SUM_BITS'(tail_value);
    assign chain_full = link[MAX_ITEMS-1].occ;
    assign two_left   = link[1].occ;
    assign accept     = start && (state_reg == ST_IDLE);

    // Commands to the chain.
    always_comb
    begin
        ctrl = '0;
        if (state_reg == ST_IDLE)
        begin
            ctrl.insert = accept && !chain_full;
        end
        else if (two_left)
        begin
            if (pair_sum == target_reg)
            begin
                ctrl.pop_left  = 1'b1;
                ctrl.pop_right = 1'b1;
            end
            else if (pair_sum < target_reg)
            begin
                ctrl.pop_left = 1'b1;
            end
            else
            begin
                ctrl.pop_right = 1'b1;
            end
        end
        else
        begin
            ctrl.clear = 1'b1;
        end
    end

    // Target register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= pair_target;
        end
    end

    // Controller: a match is held back until the next match or the scan's end so the final one can carry last_result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            overflow_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            pend_lo_reg      <= '0;
            pend_hi_reg      <= '0;
            low_value_reg    <= '0;
            high_value_reg   <= '0;
            found_reg        <= 1'b0;
            dropped_reg      <= 1'b0;
            last_result_reg  <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (chain_full)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (last_item)
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (two_left)
                    begin
                        if (pair_sum == target_reg)
                        begin
                            if (pend_valid_reg)
                            begin
                                result_valid_reg <= 1'b1;
                                low_value_reg    <= pend_lo_reg;
                                high_value_reg   <= pend_hi_reg;
                                found_reg        <= 1'b1;
                                dropped_reg      <= overflow_reg;
                                last_result_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_lo_reg    <= head_value;
                            pend_hi_reg    <= tail_value;
                        end
                    end
                    else
                    begin
                        // Closing record: the held match, or the no-pair word.
                        result_valid_reg <= 1'b1;
                        low_value_reg    <= pend_valid_reg ? pend_lo_reg : '0;
                        high_value_reg   <= pend_valid_reg ? pend_hi_reg : '0;
                        found_reg        <= pend_valid_reg;
                        dropped_reg      <= overflow_reg;
                        last_result_reg  <= 1'b1;
                        pend_valid_reg   <= 1'b0;
                        overflow_reg     <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign low_value    = low_value_reg;
    assign high_value   = high_value_reg;
    assign found        = found_reg;
    assign dropped      = dropped_reg;
    assign last_result  = last_result_reg;

endmodule

`default_nettype wire

@@ design/pps_cell.sv @@
`default_nettype none

module pps_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire pps_pkg::pps_ctrl_t  ctrl,
    input  wire pps_pkg::value_t     new_value,
    input  wire pps_pkg::pps_link_t  lower,
    input  wire pps_pkg::pps_link_t  upper,
    output pps_pkg::pps_link_t       link
);
    import pps_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   occ_reg;
    logic   occ_next;
    logic   gt;
    logic   is_tail;

    // The new word belongs at or below this cell when the cell is empty or larger.
    assign gt      = !occ_reg || ($signed(value_reg) > $signed(new_value));
    // The last occupied cell holds the right end of the set.
    assign is_tail = occ_reg && !upper.occ;

    assign link = '{value: value_reg, occ: occ_reg, gt: gt, tail: is_tail};

    // Next contents: sorted insert shifts up, a left pop shifts down,
    // a right pop frees the tail cell, a clear empties the cell.
    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            occ_next = occ_reg | lower.occ;
            if (gt)
            begin
                value_next = lower.gt ? lower.value : new_value;
            end
        end
        else if (ctrl.pop_left)
        begin
            value_next = upper.value;
            occ_next   = ctrl.pop_right ? (upper.occ && !upper.tail) : upper.occ;
        end
        else if (ctrl.pop_right)
        begin
            occ_next = occ_reg && !is_tail;
        end
    end

    // Occupancy is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // The stored value needs no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ design/pps_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module pps_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   start,
    input wire                   busy,
    input wire                   last_item,
    input wire                   result_valid,
    input wire pps_pkg::value_t  low_value,
    input wire pps_pkg::value_t  high_value,
    input wire                   found,
    input wire                   last_result
);

    logic nopair_ok;

    // A no-pair word must close the set with both values at zero.
    assign nopair_ok = last_result && (low_value == '0) && (high_value == '0);

    // Closing a set starts the search.
    `PPS_ASSERT_NEXT(a_last_starts_scan, clk, rst_n, start && !busy && last_item, busy, "no search")

    // Only the final record of a set appears once the block is idle again.
    `PPS_ASSERT_SAME(a_mid_record_busy, clk, rst_n, result_valid && !last_result, busy, "idle pair")

    // The final record frees the block.
    `PPS_ASSERT_SAME(a_final_frees, clk, rst_n, result_valid && last_result, !busy, "still busy")

    // A no-pair word closes the set and carries zero values.
    `PPS_ASSERT_SAME(a_nopair_last, clk, rst_n, result_valid && !found, nopair_ok, "bad no-pair")

endmodule

bind sorted_two_pointer_pair_sum pps_checker u_pps_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
module tb;
    import pps_pkg::*;

    // One word waiting to be sent, and one record the block should emit.
    typedef struct {
        value_t v;
        logic   closes;
    } set_word_t;

    typedef struct {
        value_t low;
        value_t high;
        logic   found;
        logic   dropped;
        logic   closing;
    } pair_record_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    value_t value = '0;
    logic   last_item = 1'b0;
    logic   cfg_valid = 1'b0;
    sum_t   pair_target = '0;
    logic   busy;
    logic   cfg_ready;
    logic   result_valid;
    value_t low_value;
    value_t high_value;
    logic   found;
    logic   dropped;
    logic   last_result;

    set_word_t    pending_words[$];
    pair_record_t expected_records[$];

    // Our own copy of the block state: the open set, the spill flag, the target.
    int   held_values[$];
    bit   spilled = 1'b0;
    sum_t goal = '0;

    bit word_taken = 1'b0;
    bit calm = 1'b0;
    int mismatches = 0;

    sorted_two_pointer_pair_sum dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last_item    (last_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .pair_target  (pair_target),
        .result_valid (result_valid),
        .low_value    (low_value),
        .high_value   (high_value),
        .found        (found),
        .dropped      (dropped),
        .last_result  (last_result)
    );

    always #1 clk = ~clk;

    task report(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Take one accepted word into the open set; on the closing word, sort the
    // set, run the two-pointer scan and queue the records it yields.
    task automatic absorb_word(input value_t v, input logic closes);
        int keys[MAX_ITEMS];
        int pair_lo[$];
        int pair_hi[$];
        int n;
        int i;
        int j;
        int key;
        int left;
        int right;
        int s;
        int tgt;
        pair_record_t r;

        if (held_values.size() < MAX_ITEMS)
            held_values.push_back(int'(v));
        else
            spilled = 1'b1;
        if (!closes)
            return;

        n = held_values.size();
        for (i = 0; i < n; i++)
            keys[i] = held_values[i];
        for (i = 1; i < n; i++)
        begin
            key = keys[i];
            j = i;
            while (j > 0 && keys[j-1] > key)
            begin
                keys[j] = keys[j-1];
                j--;
            end
            keys[j] = key;
        end

        tgt = int'(goal);
        left = 0;
        right = n - 1;
        while (left < right)
        begin
            s = keys[left] + keys[right];
            if (s == tgt)
            begin
                pair_lo.push_back(keys[left]);
                pair_hi.push_back(keys[right]);
                left++;
                right--;
            end
            else if (s < tgt)
                left++;
            else
                right--;
        end

        r.dropped = spilled;
        if (pair_lo.size() == 0)
        begin
            r.low = '0;
            r.high = '0;
            r.found = 1'b0;
            r.closing = 1'b1;
            expected_records.push_back(r);
        end
        else
        begin
            for (i = 0; i < pair_lo.size(); i++)
            begin
                r.low = VALUE_BITS'(pair_lo[i]);
                r.high = VALUE_BITS'(pair_hi[i]);
                r.found = 1'b1;
                r.closing = (i == pair_lo.size() - 1);
                expected_records.push_back(r);
            end
        end
        held_values.delete();
        spilled = 1'b0;
    endtask

    // Compare the record on the result ports with the oldest expectation.
    task automatic check_record();
        pair_record_t e;

        if (expected_records.size() == 0)
        begin
            report($sformatf("record (%0d, %0d) with none expected", low_value, high_value));
            return;
        end
        e = expected_records.pop_front();
        if (low_value !== e.low)
            report($sformatf("low_value %0d, expected %0d", low_value, e.low));
        if (high_value !== e.high)
            report($sformatf("high_value %0d, expected %0d", high_value, e.high));
        if (found !== e.found)
            report($sformatf("found %b, expected %b", found, e.found));
        if (dropped !== e.dropped)
            report($sformatf("dropped %b, expected %b", dropped, e.dropped));
        if (last_result !== e.closing)
            report($sformatf("last_result %b, expected %b", last_result, e.closing));
    endtask

    // Monitor: sample handshakes and results at the rising edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            word_taken = 1'b0;
        else
        begin
            if (result_valid)
                check_record();
            word_taken = start && !busy;
            if (word_taken)
                absorb_word(value, last_item);
        end
    end

    // Driver: hold a word until it is taken, then offer the next one or idle.
    always @(negedge clk)
    begin : drive
        set_word_t w;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || word_taken)
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 35))
            begin
                w = pending_words.pop_front();
                value <= w.v;
                last_item <= w.closes;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    task add_word(input int v, input bit closes);
        set_word_t w;
        w.v = VALUE_BITS'(v);
        w.closes = closes;
        pending_words.push_back(w);
    endtask

    // Wait until every word is sent and every record has come, then keep
    // watching the result ports for stray records.
    task settle();
        while (pending_words.size() != 0 || start || expected_records.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task write_target(input int t);
        @(negedge clk);
        cfg_valid <= 1'b1;
        pair_target <= SUM_BITS'(t);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        goal = SUM_BITS'(t);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One member of a pair whose partner still fits in a value.
    function automatic int pick_half(input int t);
        int lo;
        int hi;
        lo = (t - 32767 > -32768) ? t - 32767 : -32768;
        hi = (t + 32768 < 32767) ? t + 32768 : 32767;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // A set of n words, mostly matching pairs for the current target, with
    // random words mixed in, shuffled.
    task automatic random_set(input int n);
        int vals[$];
        int a;
        int i;
        int k;
        int tmp;
        value_t noise;

        while (vals.size() < n)
        begin
            if (vals.size() + 2 <= n && $urandom_range(99) < 60)
            begin
                a = pick_half(int'(goal));
                vals.push_back(a);
                vals.push_back(int'(goal) - a);
            end
            else
            begin
                noise = VALUE_BITS'($urandom);
                vals.push_back(int'(noise));
            end
        end
        for (i = n - 1; i > 0; i--)
        begin
            k = $urandom_range(i);
            tmp = vals[i];
            vals[i] = vals[k];
            vals[k] = tmp;
        end
        for (i = 0; i < n; i++)
            add_word(vals[i], i == n - 1);
    endtask

    initial
    begin : stimulus
        int p;
        int s;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Target at its reset value: extremes, equal values, a lone word,
        // and a set with no pair.
        add_word(-32768, 0);
        add_word(32767, 0);
        add_word(0, 0);
        add_word(0, 0);
        add_word(-5, 0);
        add_word(5, 1);
        add_word(-1, 1);
        add_word(1, 0);
        add_word(2, 1);
        settle();

        // Lowest target, and the highest sum that two values can reach.
        write_target(-65536);
        add_word(-32768, 0);
        add_word(-32768, 1);
        settle();
        write_target(65534);
        add_word(32767, 0);
        add_word(100, 0);
        add_word(32767, 1);
        settle();

        // Repeated values on both sides of the scan.
        write_target(17);
        add_word(3, 0);
        add_word(14, 0);
        add_word(14, 0);
        add_word(3, 0);
        add_word(17, 1);
        settle();

        // Random targets with back-to-back small sets; one phase without gaps.
        for (p = 0; p < 6; p++)
        begin
            calm = (p == 2);
            write_target(-65536 + int'($urandom_range(131070)));
            for (s = 0; s < 5; s++)
                random_set($urandom_range(1, 8));
            settle();
        end
        calm = 1'b0;

        // A set that just fills the store, and one that spills its last words.
        write_target(-65536 + int'($urandom_range(131070)));
        random_set(MAX_ITEMS);
        random_set(MAX_ITEMS + 2);
        settle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/pps_pkg.sv
design/pps_cell.sv
design/sorted_two_pointer_pair_sum.sv
design/pps_checker.sv
tb/tb.sv
